[rtl/core/lbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky-bucket shaper package
// Shared widths, constants, codes and the command word passed from the front
// end to the back end of the shaper.
// ----------------------------------------------------------------------------
package lbs_pkg;

   // Field widths of the payload.
   localparam int SIZE_W  = 16;
   localparam int ID_W    = 16;
   localparam int ENTRY_W = ID_W + SIZE_W;

   // Default number of packet slots in the queue.
   localparam int QUEUE_DEPTH_DEF = 16;

   // Most packets sent by one tick, and the width of the counter for it.
   localparam int MAX_RESULTS = 16;
   localparam int SENT_W      = $clog2(MAX_RESULTS + 1);

   // Register file: two 16-bit registers at byte addresses 0 and 4.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'd1000;
   localparam logic [SIZE_W-1:0] LEAK_RESET     = 16'd400;

   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_LEAK     = 1'b1
   } reg_index_type;

   // Operation codes of an input word.
   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Status codes of a result word.
   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_REJECTED = 2'd1,
      ST_SENT     = 2'd2,
      ST_IDLE     = 2'd3
   } status_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      op_type              op;
      logic [SIZE_W-1:0]   size;
   } cmd_type;

endpackage

[rtl/core/leaky_bucket_packet_shaper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky-bucket packet shaper
// Byte-based shaper: add words queue packets within a byte capacity, tick
// words drain queued packets in order within a per-tick byte budget.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    operation, packet_size
// rsp       out        rsp_valid/ready    status, packet_id, last
// csr       in/out     psel/penable       paddr, pwdata, prdata (capacity, leak)
//
// Adds flow at one per cycle while the result word is not stalled; an add's
// result word is registered and valid in the cycle after acceptance.
// A tick starts, sends one packet per cycle (at most 16) unless the result
// word stalls, and closes with the last or idle word, paced by the single
// read port of the queue RAM; the back end takes no new command until it closes.
// Reset is synchronous; it empties the queue, clears occupancy, sets the next
// id to one and loads capacity 1000 and leak rate 400.
// A stalled result word holds the back end; a two-word queue in front keeps
// taking input words until it fills.
// ----------------------------------------------------------------------------
module leaky_bucket_packet_shaper
   import lbs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [SIZE_W-1:0]     req_packet_size,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [ID_W-1:0]       rsp_packet_id,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [SIZE_W-1:0] capacity_ff, capacity_in;
   logic [SIZE_W-1:0] leak_ff, leak_in;
   reg_index_type     reg_index;
   logic              csr_write;
   logic              cmd_valid;
   logic              cmd_ready;
   cmd_type           cmd;

   // Register file: writes complete in the access phase.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      capacity_in = capacity_ff;
      leak_in     = leak_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_CAPACITY: capacity_in = pwdata[SIZE_W-1:0];
            REG_LEAK:     leak_in     = pwdata[SIZE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_CAPACITY: prdata = {{(CSR_DATA_W - SIZE_W){1'b0}}, capacity_ff};
         REG_LEAK:     prdata = {{(CSR_DATA_W - SIZE_W){1'b0}}, leak_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         leak_ff     <= LEAK_RESET;
      end else begin
         capacity_ff <= capacity_in;
         leak_ff     <= leak_in;
      end
   end

   // Front end: accept and classify input words.
   lbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_packet_size (req_packet_size),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd)
   );

   // Back end: queue management and result generation.
   lbs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd),
      .capacity_bytes (capacity_ff),
      .leak_rate      (leak_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_packet_id  (rsp_packet_id),
      .rsp_last       (rsp_last)
   );

endmodule

[rtl/core/lbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lbs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shaper front end
// Accepts input words, classifies them into add or tick commands and holds
// them in a two-entry queue ahead of the back end.
// ----------------------------------------------------------------------------
module lbs_front
   import lbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [SIZE_W-1:0] req_packet_size,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cmd_type           cmd
);

   cmd_type    cmd_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   // Classify the incoming word; a tick carries no size.
   always_comb begin
      cmd_in.op   = op_type'(req_operation);
      cmd_in.size = (cmd_in.op == OP_TICK) ? '0 : req_packet_size;
   end

   assign req_ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = cmd_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

[rtl/core/lbs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shaper back end
// Executes add and tick commands against the packet queue, keeps the byte
// occupancy and id counter, and drives the registered result word.
// ----------------------------------------------------------------------------
module lbs_back
   import lbs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   input  logic [SIZE_W-1:0] capacity_bytes,
   input  logic [SIZE_W-1:0] leak_rate,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_packet_id,
   output logic              rsp_last
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SENT_W-1:0] SENT_LIMIT = SENT_W'(MAX_RESULTS);

   typedef enum logic {
      S_IDLE = 1'b0,
      S_TICK = 1'b1
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] occ_ff, occ_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;
   logic [SIZE_W-1:0] budget_ff, budget_in;
   logic [SENT_W-1:0] sent_ff, sent_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               can_emit;
   logic [SIZE_W:0]    occ_sum;
   logic               fits_cap;
   logic               has_room;
   logic               fits_budget;
   logic [PTR_W-1:0]   head_step;
   logic [PTR_W-1:0]   tail_step;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [SIZE_W-1:0]  rd_size;

   // Packet queue storage: id in the upper half, size in the lower half.
   lbs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_data),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign wr_data = {next_id_ff, cmd.size};
   assign rd_id   = rd_data[ENTRY_W-1:SIZE_W];
   assign rd_size = rd_data[SIZE_W-1:0];

   // The result register can take a new word when empty or being drained.
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && can_emit;

   // Admission checks for an add.
   assign occ_sum  = {1'b0, occ_ff} + {1'b0, cmd.size};
   assign fits_cap = (occ_sum <= {1'b0, capacity_bytes});
   assign has_room = (count_ff != FULL_COUNT);

   // Pointer wrap at the queue depth.
   assign head_step = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
   assign tail_step = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);

   // The head packet may go out on this tick.
   assign fits_budget = (count_ff != '0) && (sent_ff != SENT_LIMIT) &&
                        (rd_size <= budget_ff);

   // Next-state logic. During a tick the RAM reads the next head every cycle,
   // so one packet leaves per cycle unless the result word stalls. A sent packet
   // is held in the pending slot until it is known whether another one follows.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      occ_in        = occ_ff;
      next_id_in    = next_id_ff;
      budget_in     = budget_ff;
      sent_in       = sent_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               if (cmd.op == OP_TICK) begin
                  state_in      = S_TICK;
                  budget_in     = leak_rate;
                  sent_in       = '0;
                  pend_valid_in = 1'b0;
               end else begin
                  next_id_in   = next_id_ff + ID_W'(1);
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = next_id_ff;
                  rsp_last_in  = 1'b1;
                  if (fits_cap && has_room) begin
                     wr_en         = 1'b1;
                     tail_in       = tail_step;
                     count_in      = count_ff + CNT_W'(1);
                     occ_in        = occ_sum[SIZE_W-1:0];
                     rsp_status_in = ST_ACCEPTED;
                  end else begin
                     rsp_status_in = ST_REJECTED;
                  end
               end
            end
         end
         S_TICK: begin
            if (fits_budget) begin
               if (!pend_valid_ff || can_emit) begin
                  head_in       = head_step;
                  count_in      = count_ff - CNT_W'(1);
                  occ_in        = (occ_ff >= rd_size) ? occ_ff - rd_size : '0;
                  budget_in     = budget_ff - rd_size;
                  sent_in       = sent_ff + SENT_W'(1);
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_id;
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_SENT;
                     rsp_id_in     = pend_id_ff;
                     rsp_last_in   = 1'b0;
                  end
               end
            end else if (can_emit) begin
               // Tick ends: flush the pending packet as last, or report idle.
               state_in      = S_IDLE;
               pend_valid_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_status_in = ST_SENT;
                  rsp_id_in     = pend_id_ff;
               end else begin
                  rsp_status_in = ST_IDLE;
                  rsp_id_in     = '0;
               end
            end
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         occ_ff        <= '0;
         next_id_ff    <= ID_W'(1);
         sent_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         occ_ff        <= occ_in;
         next_id_ff    <= next_id_in;
         sent_ff       <= sent_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      budget_ff     <= budget_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_packet_id = rsp_id_ff;
   assign rsp_last      = rsp_last_ff;

   // The queue never holds more packets than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("packet queue count exceeds its depth");

   // A tick never sends more than the result limit.
   assert property (@(posedge clock) disable iff (reset)
      sent_ff <= SENT_LIMIT)
      else $error("tick sent more packets than allowed");

   // Only a sent packet may be followed by more words of the same tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_status_ff == ST_SENT)
      else $error("non-final result word is not a sent packet");

   // An idle tick reports id zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_IDLE |-> rsp_id_ff == '0)
      else $error("idle tick result carries a nonzero id");

   // A packet is pending only while a tick is running.
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> state_ff == S_TICK)
      else $error("pending packet outside a tick");

endmodule
